### src/audio_activity_detector_core_assert.svh
// Assertion macros for the activity detector. The clock is clock, the reset is reset.
`ifndef AUDIO_ACTIVITY_DETECTOR_CORE_ASSERT_SVH
`define AUDIO_ACTIVITY_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AAD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("activity detector check failed");
`define AAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("activity detector check failed");
`else
`define AAD_ASSERT_SAME(label, ante, cons)
`define AAD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/aad_pkg.sv
`timescale 1ns / 1ps
package aad_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int MEAN_SHIFT  = 6;
   localparam int AVG_SHIFT   = 4;

   localparam int MEAN_W = 17;
   localparam int AC_W   = 11;
   localparam int AVG_W  = 15;
   localparam int THR_W  = 10;
   localparam int WIN_W  = 14;
   localparam int HOLD_W = 16;
   // wide working widths for the signed sums
   localparam int ACX_W  = 12;
   localparam int SUM_W  = 17;

   localparam logic signed [SUM_W-1:0] AVG_LIMIT = 17'sd16383;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIGGER_THRESHOLD = 2'd0,
      CSR_LOCK_WINDOW       = 2'd1,
      CSR_HOLDOFF_SAMPLES   = 2'd2
   } csr_index_type;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 10'd15;
   localparam logic [WIN_W-1:0]  WINDOW_RESET    = 14'd100;
   localparam logic [HOLD_W-1:0] HOLDOFF_RESET   = 16'd4808;

   typedef struct packed {
      logic [THR_W-1:0]  trigger_threshold;
      logic [WIN_W-1:0]  lock_window;
      logic [HOLD_W-1:0] holdoff_samples;
   } cfg_type;

   typedef struct packed {
      logic [MEAN_W-1:0]       mean_accum;
      logic signed [AVG_W-1:0] ac_average;
      logic                    lock_flag;
      logic                    led_level;
      logic [HOLD_W-1:0]       holdoff_count;
   } state_type;

   typedef struct packed {
      logic signed [AC_W-1:0]  ac_level;
      logic signed [AVG_W-1:0] avg_level;
      logic                    triggered;
      logic                    led_on;
      logic                    lock_event;
      logic                    skipped;
   } result_type;

endpackage

### src/aad_csr.sv
`timescale 1ns / 1ps
module aad_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aad_pkg::CSR_DATA_W-1:0]      csr_data,
   output aad_pkg::cfg_type                    cfg
);

   aad_pkg::cfg_type cfg_ff;
   aad_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (aad_pkg::csr_index_type'(csr_index))
            aad_pkg::CSR_TRIGGER_THRESHOLD:
               cfg_in.trigger_threshold = csr_data[aad_pkg::THR_W-1:0];
            aad_pkg::CSR_LOCK_WINDOW:
               cfg_in.lock_window = csr_data[aad_pkg::WIN_W-1:0];
            aad_pkg::CSR_HOLDOFF_SAMPLES:
               cfg_in.holdoff_samples = csr_data[aad_pkg::HOLD_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_threshold <= aad_pkg::THRESHOLD_RESET;
         cfg_ff.lock_window       <= aad_pkg::WINDOW_RESET;
         cfg_ff.holdoff_samples   <= aad_pkg::HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/aad_compute.sv
`timescale 1ns / 1ps
module aad_compute (
   input  logic [aad_pkg::SAMPLE_BITS-1:0] sample,
   input  aad_pkg::cfg_type                cfg,
   input  aad_pkg::state_type              state,
   output aad_pkg::state_type              state_next,
   output aad_pkg::result_type             result
);

   logic [aad_pkg::MEAN_W-1:0]        mean_q;
   logic signed [aad_pkg::ACX_W-1:0]  ac;
   logic signed [aad_pkg::ACX_W-1:0]  thr;
   logic signed [aad_pkg::SUM_W-1:0]  avg_ext;
   logic signed [aad_pkg::SUM_W-1:0]  avg_quot;
   logic signed [aad_pkg::SUM_W-1:0]  avg_sum;
   logic signed [aad_pkg::SUM_W-1:0]  avg_sat;
   logic signed [aad_pkg::SUM_W-1:0]  win;
   logic                              in_window;
   logic                              trig;

   assign mean_q = state.mean_accum >> aad_pkg::MEAN_SHIFT;
   assign ac     = $signed({2'b00, sample}) - $signed({1'b0, mean_q[aad_pkg::ACX_W-2:0]});
   assign thr    = $signed({2'b00, cfg.trigger_threshold});

   // truncate toward zero: bias negative values before the arithmetic shift
   assign avg_ext  = aad_pkg::SUM_W'(state.ac_average);
   assign avg_quot = $signed(avg_ext + (avg_ext < 0 ? aad_pkg::SUM_W'((1 << aad_pkg::AVG_SHIFT) - 1)
                                                    : aad_pkg::SUM_W'(0))) >>> aad_pkg::AVG_SHIFT;
   assign avg_sum  = avg_ext + aad_pkg::SUM_W'(ac) - avg_quot;

   always_comb begin
      if (avg_sum > aad_pkg::AVG_LIMIT) begin
         avg_sat = aad_pkg::AVG_LIMIT;
      end else if (avg_sum < -aad_pkg::AVG_LIMIT) begin
         avg_sat = -aad_pkg::AVG_LIMIT;
      end else begin
         avg_sat = avg_sum;
      end
   end

   assign win       = $signed({3'b000, cfg.lock_window});
   assign in_window = (avg_sat < win) && (avg_sat > -win);
   assign trig      = in_window && ((ac > thr) || (ac < -thr));

   always_comb begin
      state_next = state;
      result     = '0;
      if (state.holdoff_count != '0) begin
         // hold everything but the holdoff count
         state_next.holdoff_count = state.holdoff_count - 1'b1;
         result.avg_level         = state.ac_average;
         result.led_on            = state.led_level;
         result.skipped           = 1'b1;
      end else begin
         state_next.mean_accum = state.mean_accum - mean_q
                                 + aad_pkg::MEAN_W'(sample);
         state_next.ac_average = avg_sat[aad_pkg::AVG_W-1:0];
         state_next.lock_flag  = state.lock_flag | in_window;
         state_next.led_level  = state.led_level ^ trig;
         if (trig) begin
            state_next.holdoff_count = cfg.holdoff_samples;
         end
         result.ac_level   = ac[aad_pkg::AC_W-1:0];
         result.avg_level  = avg_sat[aad_pkg::AVG_W-1:0];
         result.triggered  = trig;
         result.led_on     = state.led_level ^ trig;
         result.lock_event = in_window & ~state.lock_flag;
      end
   end

endmodule

### src/audio_activity_detector_core.sv
`timescale 1ns / 1ps
// Audio activity detector: DC removal by a leaky mean, a leaky AC average,
// a one-time lock indication and an LED toggle on loud samples in the lock window.
// req_ channel: one converter sample per request in req_tdata[9:0].
// rsp_ channel: one result per request; rsp_tuser marks a sample ignored
// during the holdoff that follows a trigger.
// csr_ channel: register writes by index (0 trigger threshold, 1 lock window,
// 2 holdoff samples); taken every cycle. The user must write only while no
// request is in flight; the block itself does not enforce it. A request
// passes an input register, then the combinational datapath into the result
// register. Throughput is one request per clock while rsp_tready does not
// stall; the detector state closes its feedback loop within the datapath.
// A stalled rsp_tready holds the result register; the input register still
// takes one more request, then req_tready drops until the result is taken.
// Synchronous reset clears the pipeline, the detector state and restores the
// register defaults.
module audio_activity_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // sample[9:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // ac_level[10:0], avg_level[25:11], triggered[26], led_on[27], lock_event[28]
   output logic [31:0]                        rsp_tdata,
   output logic                               rsp_tuser,   // skipped[0]
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [aad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aad_pkg::CSR_DATA_W-1:0]     csr_data
);

`include "audio_activity_detector_core_assert.svh"

   aad_pkg::cfg_type                 cfg;
   aad_pkg::state_type               state_ff;
   aad_pkg::state_type               state_in;
   aad_pkg::result_type              result_in;
   aad_pkg::result_type              rsp_ff;
   logic                             in_valid_ff;
   logic [aad_pkg::SAMPLE_BITS-1:0]  in_sample_ff;
   logic                             rsp_valid_ff;
   logic                             out_free;
   logic                             advance;

   aad_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   aad_compute u_compute (
      .sample     (in_sample_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_sample_ff <= req_tdata[aad_pkg::SAMPLE_BITS-1:0];
      end
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.lock_event, rsp_ff.led_on, rsp_ff.triggered,
                        rsp_ff.avg_level, rsp_ff.ac_level};
   assign rsp_tuser  = rsp_ff.skipped;

   // a skipped result carries no new level and no events
   `AAD_ASSERT_SAME(a_skip_quiet, rsp_valid_ff && rsp_ff.skipped,
      !rsp_ff.triggered && !rsp_ff.lock_event && rsp_ff.ac_level == '0)
   // a pending holdoff makes the next result a skipped one
   `AAD_ASSERT_NEXT(a_holdoff_skips, advance && state_ff.holdoff_count != '0,
      rsp_valid_ff && rsp_ff.skipped)
   // a trigger flips the LED level
   `AAD_ASSERT_NEXT(a_trig_toggles, advance && result_in.triggered,
      state_ff.led_level != $past(state_ff.led_level))
   // the lock indication fires once and leaves the lock set
   `AAD_ASSERT_NEXT(a_lock_sticks, advance && result_in.lock_event,
      state_ff.lock_flag)
   // the saturated average never reaches the most negative code
   `AAD_ASSERT_SAME(a_avg_range, in_valid_ff, state_ff.ac_average != -16'sd16384)

endmodule
